// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;
    localparam int MOD_WIDTH = 30;
    localparam int BASE_WIDTH = 31;
    localparam int EXP_WIDTH = 32;
    localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(1000000007);
    // exponent scan covers the wider of the input exponent and the modulus
    localparam int SCAN_WIDTH = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
    localparam int SCAN_CNT_W = $clog2(SCAN_WIDTH);
    localparam int MUL_CNT_W = $clog2(MOD_WIDTH);
    localparam int RED_CNT_W = $clog2(BASE_WIDTH + 1);
    localparam logic ACT_POWER = 1'b0;
    localparam logic ACT_INVERSE = 1'b1;
endpackage

// ===== rtl/mexp_if.sv =====
interface mexp_in_if;
    import mexp_pkg::*;
    logic valid;
    logic ready;
    logic action;
    logic [BASE_WIDTH-1:0] base;
    logic [EXP_WIDTH-1:0] exponent;
    modport source (output valid, output action, output base, output exponent, input ready);
    modport sink (input valid, input action, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
    import mexp_pkg::*;
    logic valid;
    logic ready;
    logic [MOD_WIDTH-1:0] result;
    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

// ===== rtl/modular_exponentiation.sv =====
// channel   dir   handshake       payload
// i_in      in    valid/ready     action, base, exponent
// o_out     out   valid/ready     result
// cfg       in    i_cfg_we        i_cfg_data (modulus)
//
// one item at a time; the base is first reduced bit-serially,
// then 32 exponent bits are scanned, each costing a shift-and-add
// squaring plus, where the bit is one, another shift-and-add multiply
// synchronous active-low reset; the result register holds until taken, a new
// transaction is accepted whenever the engine is idle and a finished result
// waits in S_DONE only while the previous one is still unread
module modular_exponentiation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mexp_pkg::MOD_WIDTH-1:0] i_cfg_data,
    mexp_in_if.sink                     i_in,
    mexp_out_if.source                  o_out
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_SQR  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_b, n_b;       // reduced base
    logic [MOD_WIDTH-1:0] r_acc, n_acc;   // power accumulator
    logic [MOD_WIDTH:0]   r_pa, n_pa;     // partial product, one spare bit
    logic [MOD_WIDTH-1:0] r_mb, n_mb;     // multiplier bits, shifted out msb first
    logic [BASE_WIDTH-1:0] r_bsh, n_bsh;  // base bits for reduction
    logic [SCAN_WIDTH-1:0] r_e, n_e;      // exponent bits, msb first
    logic [SCAN_CNT_W-1:0] r_ecnt, n_ecnt;
    logic [MUL_CNT_W-1:0]  r_mcnt, n_mcnt;
    logic [RED_CNT_W-1:0]  r_rcnt, n_rcnt;
    logic [MOD_WIDTH-1:0] r_res, n_res;
    logic r_ovalid, n_ovalid;

    // one shift-and-add step: acc = 2*acc (+ addend, or + base bit when reducing) mod m
    logic [MOD_WIDTH+1:0] w_dbl, w_dbl_r, w_add;
    logic [MOD_WIDTH-1:0] w_addend, w_step;
    logic w_bit;

    always_comb begin
        w_bit = (r_state == S_RED) ? r_bsh[BASE_WIDTH-1] : r_mb[MOD_WIDTH-1];
        w_addend = (r_state == S_SQR) ? r_acc : r_b;
        w_dbl = {r_pa, 1'b0};
        w_dbl_r = (w_dbl >= {2'b00, r_mod}) ? w_dbl - {2'b00, r_mod} : w_dbl;
        if (r_state == S_RED) begin
            w_add = w_dbl_r + (MOD_WIDTH+2)'(w_bit);
        end else begin
            w_add = w_dbl_r + (w_bit ? {2'b00, w_addend} : '0);
        end
        w_step = (w_add >= {2'b00, r_mod}) ? MOD_WIDTH'(w_add - {2'b00, r_mod})
                                           : MOD_WIDTH'(w_add);
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.result = r_res;

    always_comb begin
        n_state = r_state;
        n_b = r_b; n_acc = r_acc; n_pa = r_pa; n_mb = r_mb; n_bsh = r_bsh;
        n_e = r_e; n_ecnt = r_ecnt; n_mcnt = r_mcnt; n_rcnt = r_rcnt;
        n_res = r_res;
        n_ovalid = r_ovalid && !o_out.ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_bsh = i_in.base;
                    n_e = (i_in.action == ACT_INVERSE) ?
                          SCAN_WIDTH'(r_mod - MOD_WIDTH'(2)) : SCAN_WIDTH'(i_in.exponent);
                    n_pa = '0;
                    n_rcnt = '0;
                    n_acc = MOD_WIDTH'(1);
                    n_ecnt = '0;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                n_pa = {1'b0, w_step};
                n_bsh = r_bsh << 1;
                n_rcnt = r_rcnt + 1'b1;
                if (r_rcnt == RED_CNT_W'(BASE_WIDTH - 1)) begin
                    n_b = w_step;
                    n_pa = '0;
                    n_mb = r_acc;
                    n_mcnt = '0;
                    n_state = S_SQR;
                end
            end
            S_SQR, S_MUL: begin
                n_pa = {1'b0, w_step};
                n_mb = r_mb << 1;
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == MUL_CNT_W'(MOD_WIDTH - 1)) begin
                    n_acc = w_step;
                    n_pa = '0;
                    n_mcnt = '0;
                    n_mb = w_step;
                    if (r_state == S_SQR && r_e[SCAN_WIDTH-1]) begin
                        n_state = S_MUL;
                    end else if (r_ecnt == SCAN_CNT_W'(SCAN_WIDTH - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_e = r_e << 1;
                        n_ecnt = r_ecnt + 1'b1;
                        n_state = S_SQR;
                    end
                end
            end
            S_DONE: begin
                // wait here while the previous result is still unread
                if (!r_ovalid || o_out.ready) begin
                    // a power mod 1 or 0 has no residue, so zero is returned
                    n_res = (r_mod < MOD_WIDTH'(2)) ? '0 : r_acc;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_mod <= MOD_RESET;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
        end
        r_b <= n_b; r_acc <= n_acc; r_pa <= n_pa; r_mb <= n_mb; r_bsh <= n_bsh;
        r_e <= n_e; r_ecnt <= n_ecnt; r_mcnt <= n_mcnt; r_rcnt <= n_rcnt;
        r_res <= n_res;
    end

`ifndef NO_ASSERTIONS
    a_res_lt_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) && r_mod >= MOD_WIDTH'(2) |-> r_res < r_mod)
        else $error("result not reduced");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid && $stable(r_res))
        else $error("result lost under stall");
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_in.ready)
        else $error("accept while busy");
    a_pa_lt_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQR || r_state == S_MUL) && r_mod >= MOD_WIDTH'(2)
        |-> r_pa < {1'b0, r_mod})
        else $error("partial product out of range");
`endif
endmodule

// ===== test/modular_exponentiation_tb.sv =====
module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mexp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [MOD_WIDTH-1:0] i_cfg_data = '0;

    mexp_in_if in_ch ();
    mexp_out_if out_ch ();

    modular_exponentiation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state: the modulus as the block holds it
    logic [MOD_WIDTH-1:0] cur_modulus = MOD_RESET;
    logic [MOD_WIDTH-1:0] pending_results[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // bound on one item at worst, with margins; used as the final wait
    localparam int unsigned ITEM_CYCLES = 2200;
    localparam int unsigned CYCLE_LIMIT = 40_000_000;

    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] acc;
        acc = 0;
        for (int i = 63; i >= 0; i--) begin
            acc = acc + acc;
            if (acc >= m) acc -= m;
            if (b[i]) begin
                acc = acc + a;
                if (acc >= m) acc -= m;
            end
        end
        return acc;
    endfunction

    function automatic logic [MOD_WIDTH-1:0] predict_power(logic act, logic [BASE_WIDTH-1:0] b,
                                                          logic [EXP_WIDTH-1:0] e);
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] bred;
        logic [63:0] pw;
        m = 64'(cur_modulus);
        if (m < 2) return '0;
        pw = (act == ACT_INVERSE) ? m - 2 : 64'(e);
        bred = 64'(b) % m;
        acc = 1;
        for (int i = 63; i >= 0; i--) begin
            acc = mul_mod(acc, acc, m);
            if (pw[i]) acc = mul_mod(acc, bred, m);
        end
        return acc[MOD_WIDTH-1:0];
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        logic [MOD_WIDTH-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", out_ch.result);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.result !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d actual %0d", want, out_ch.result);
                end
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_POWER;
        in_ch.base = '0;
        in_ch.exponent = '0;
    end

    // one transaction, with random sender idling before it
    task automatic send_item(logic act, logic [BASE_WIDTH-1:0] b, logic [EXP_WIDTH-1:0] e);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.base <= b;
        in_ch.exponent <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results = {pending_results, predict_power(act, b, e)};
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // modulus written only with the block idle
    task automatic write_modulus(logic [MOD_WIDTH-1:0] m);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_modulus = m;
    endtask

    function automatic logic [EXP_WIDTH-1:0] rand_exponent();
        case ($urandom_range(3))
            0: return EXP_WIDTH'($urandom_range(8));
            1: return {EXP_WIDTH{1'b1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [BASE_WIDTH-1:0] rand_base();
        case ($urandom_range(5))
            0: return BASE_WIDTH'($urandom_range(2));
            1: return {BASE_WIDTH{1'b1}};
            2: return BASE_WIDTH'(cur_modulus) * BASE_WIDTH'($urandom_range(1));
            default: return BASE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        // extremes, exponent zero, inverse of zero, multiples of modulus
        send_item(ACT_POWER, '0, '0);
        send_item(ACT_POWER, BASE_WIDTH'(cur_modulus), '0);
        send_item(ACT_POWER, {BASE_WIDTH{1'b1}}, {EXP_WIDTH{1'b1}});
        send_item(ACT_POWER, BASE_WIDTH'(2), EXP_WIDTH'(30));
        send_item(ACT_POWER, BASE_WIDTH'(0), EXP_WIDTH'(5));
        send_item(ACT_INVERSE, BASE_WIDTH'(0), EXP_WIDTH'(123));
        send_item(ACT_INVERSE, BASE_WIDTH'(2), '0);
        send_item(ACT_INVERSE, {BASE_WIDTH{1'b1}}, {EXP_WIDTH{1'b1}});
        send_item(ACT_POWER, BASE_WIDTH'(cur_modulus - 1), EXP_WIDTH'(3));
        // sender waits for every result before carrying on
        wait_drained();
        send_item(ACT_INVERSE, BASE_WIDTH'(cur_modulus + 1), EXP_WIDTH'(7));
    endtask

    task automatic test_odd_moduli();
        // modulus zero and one give zero, two the smallest residue ring
        write_modulus(MOD_WIDTH'(0));
        send_item(ACT_POWER, BASE_WIDTH'(5), EXP_WIDTH'(0));
        send_item(ACT_INVERSE, BASE_WIDTH'(5), EXP_WIDTH'(9));
        write_modulus(MOD_WIDTH'(1));
        send_item(ACT_POWER, BASE_WIDTH'(7), EXP_WIDTH'(0));
        send_item(ACT_POWER, BASE_WIDTH'(7), EXP_WIDTH'(3));
        write_modulus(MOD_WIDTH'(2));
        send_item(ACT_INVERSE, BASE_WIDTH'(0), EXP_WIDTH'(0));
        send_item(ACT_INVERSE, BASE_WIDTH'(3), EXP_WIDTH'(0));
        send_item(ACT_POWER, BASE_WIDTH'(2), EXP_WIDTH'(0));
        write_modulus({MOD_WIDTH{1'b1}});
        send_item(ACT_POWER, {BASE_WIDTH{1'b1}}, {EXP_WIDTH{1'b1}});
        send_item(ACT_INVERSE, BASE_WIDTH'(12345), EXP_WIDTH'(0));
        write_modulus(MOD_WIDTH'(1000));
        send_item(ACT_INVERSE, BASE_WIDTH'(7), EXP_WIDTH'(0));
    endtask

    task automatic test_random(int unsigned n);
        logic [MOD_WIDTH-1:0] mods[6] = '{MOD_RESET, 30'd998244353, 30'd13, 30'd65537,
                                          {MOD_WIDTH{1'b1}}, 30'd2};
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                if ($urandom_range(3) == 0) write_modulus(MOD_WIDTH'($urandom));
                else write_modulus(mods[$urandom_range(5)]);
            end
            send_item(logic'($urandom_range(1)), rand_base(), rand_exponent());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 19;
        recv_idle_pct = 52;
        test_directed();
        test_odd_moduli();
        test_random(600);
        send_idle_pct = 52;
        recv_idle_pct = 19;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(600);
        wait_drained();
        repeat (ITEM_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
